[rtl/core/cdvs_pkg.sv]
// Shared types, constants and saturation helpers for the critically damped smoother.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps
`default_nettype none
package cdvs_pkg;

  localparam int NUM_AXES = 3;

  // Wide intermediates are held in 49-bit two's complement, bounded at +-(2^47 - 1).
  typedef logic signed [48:0] wide_t;
  typedef logic signed [49:0] sum_t;

  localparam logic signed [49:0] WIDE_LIM_S = 50'sd140737488355327;
  localparam logic [46:0]        WIDE_LIM_U = 47'h7FFF_FFFF_FFFF;

  localparam logic [23:0] ST_FLOOR = 24'd7;
  localparam logic [23:0] ST_RESET = 24'd6554;
  localparam logic [27:0] X_MAX    = 28'hFFF_FFFF;
  localparam logic [15:0] C_QUAD   = 16'd31457;
  localparam logic [15:0] C_CUBE   = 16'd15401;

  localparam int DIV_N_W = 49;
  localparam int DIV_D_W = 54;

  typedef struct packed {
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic [15:0]        delta_time;
    logic               seed;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               snapped;
  } out_res_t;

  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic signed [65:0] dot;
  } lane_res_t;

  function automatic sum_t ext32(input logic signed [31:0] v);
    return {{18{v[31]}}, v};
  endfunction

  function automatic sum_t extw(input wide_t v);
    return {v[48], v};
  endfunction

  function automatic wide_t sat_w(input sum_t v);
    sum_t neg_lim;
    neg_lim = -WIDE_LIM_S;
    if (v > WIDE_LIM_S) begin
      return WIDE_LIM_S[48:0];
    end else if (v < neg_lim) begin
      return neg_lim[48:0];
    end
    return v[48:0];
  endfunction

  function automatic logic signed [31:0] sat32(input wide_t v);
    if (v > 49'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -49'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

[rtl/core/critically_damped_vector_smoother.sv]
// Top level of the critically damped 3-D smoother: sequencer, shared divider, three lanes.
// Depends on cdvs_pkg, cdvs_div, cdvs_lane and cdvs_merge.
//
//   channel | ports                           | direction | payload
//   --------+---------------------------------+-----------+---------------------------
//   in      | in_valid, in_stall, in_data     | request in| target xyz, delta_time, seed
//   out     | out_valid, out_stall, out_data  | result out| smoothed xyz, snapped
//   cfg     | cfg_valid, cfg_ready, cfg_data  | write in  | smooth_time, Q8.16
//
// A seed request or a zero time step goes from S_IDLE straight to S_FIN, which commits it
// to the output register once that register is free; the next request is then taken.
// A spring step runs the two 49-step restoring divisions (omega, then the decay factor)
// on the single shared divider, with the decay polynomial between them, then the axis
// lanes and merge, then the commit of state and result in S_FIN.
// Synchronous active-low reset clears the position and velocity and sets smooth_time to 0.1 s.
// One request is in flight at a time; a finished result waits in the output register,
// so the next request is taken while it is stalled.
`timescale 1ns / 1ps
`default_nettype none
module critically_damped_vector_smoother (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire cdvs_pkg::in_req_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output cdvs_pkg::out_res_t     out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [23:0]       cfg_data
);
  import cdvs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_OMG, S_X, S_X2, S_X3, S_SUM3, S_C3, S_D, S_EDIV, S_LANE, S_FIN
  } state_t;

  state_t             state_r;
  logic [23:0]        st_r;
  logic signed [31:0] pos_r [NUM_AXES];
  logic signed [31:0] vel_r [NUM_AXES];
  logic signed [31:0] tgt_r [NUM_AXES];
  logic [15:0]        dt_r;
  logic               seed_r;
  logic               step_r;
  logic               snap_r;
  logic [30:0]        omega_r;
  logic [27:0]        x_r;
  logic [39:0]        x2_r;
  logic [51:0]        t1_r;
  logic [39:0]        t2_r;
  logic [39:0]        q2_r;
  logic [52:0]        x3_r;
  logic [52:0]        c3a_r;
  logic [15:0]        c3b_r;
  logic [32:0]        e_r;
  logic               div_go_r;
  logic [DIV_N_W-1:0] div_num_r;
  logic [DIV_D_W-1:0] div_den_r;
  logic               lane_go_r;
  logic               out_valid_r;
  out_res_t           out_data_r;

  logic               div_busy, div_done;
  logic [DIV_N_W-1:0] div_quo;
  logic [NUM_AXES-1:0] lane_done;
  lane_res_t          lane_res [NUM_AXES];
  logic               m_done, m_snap;

  logic [23:0]        st_eff;
  logic [46:0]        x_mul;
  logic [27:0]        x_sat;
  logic [55:0]        x2_mul, t2_mul, q2_mul;
  logic [31:0]        c3b_mul;
  logic [53:0]        d_sum;
  logic signed [31:0] new_pos [NUM_AXES];
  logic signed [31:0] new_vel [NUM_AXES];

  // Floor the spring time so omega stays bounded.
  assign st_eff  = (st_r < ST_FLOOR) ? ST_FLOOR : st_r;

  assign x_mul   = omega_r * dt_r;
  assign x_sat   = (x_mul[46:14] > 33'(X_MAX)) ? X_MAX : x_mul[41:14];
  assign x2_mul  = x_r * x_r;
  assign t2_mul  = x2_r * x_r[15:0];
  assign q2_mul  = x2_r * C_QUAD;
  assign c3b_mul = x3_r[15:0] * C_CUBE;
  // Denominator of the decay: 1 + x + 0.48 x^2 + 0.235 x^3, Q16.16.
  assign d_sum   = 54'd65536 + 54'(x_r) + 54'(q2_r) + 54'(c3a_r) + 54'(c3b_r);

  cdvs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go_r),
    .num   (div_num_r),
    .den   (div_den_r),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
    cdvs_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .start (lane_go_r),
      .cur   (pos_r[i]),
      .vel   (vel_r[i]),
      .tgt   (tgt_r[i]),
      .omega (omega_r),
      .dt    (dt_r),
      .e     (e_r),
      .done  (lane_done[i]),
      .res   (lane_res[i])
    );
  end

  cdvs_merge u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lane_done[0]),
    .lane  (lane_res),
    .done  (m_done),
    .snap  (m_snap)
  );

  // Next state of each axis: seed and snap land on the target, a step takes the lane
  // result, a zero step holds.
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      if (seed_r || (step_r && snap_r)) begin
        new_pos[i] = tgt_r[i];
        new_vel[i] = '0;
      end else if (step_r) begin
        new_pos[i] = lane_res[i].pos;
        new_vel[i] = lane_res[i].vel;
      end else begin
        new_pos[i] = pos_r[i];
        new_vel[i] = vel_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      st_r        <= ST_RESET;
      div_go_r    <= 1'b0;
      lane_go_r   <= 1'b0;
      out_valid_r <= 1'b0;
      seed_r      <= 1'b0;
      step_r      <= 1'b0;
      snap_r      <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        pos_r[i] <= '0;
        vel_r[i] <= '0;
      end
    end else begin
      div_go_r  <= 1'b0;
      lane_go_r <= 1'b0;
      // Drop the result once taken, unless the commit below refills the register.
      if (out_valid_r && !out_stall && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        st_r <= cfg_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            tgt_r[0] <= in_data.target_x;
            tgt_r[1] <= in_data.target_y;
            tgt_r[2] <= in_data.target_z;
            dt_r     <= in_data.delta_time;
            seed_r   <= in_data.seed;
            snap_r   <= 1'b0;
            if (in_data.seed || in_data.delta_time == '0) begin
              step_r  <= 1'b0;
              state_r <= S_FIN;
            end else begin
              // omega = 2^33 / smooth_time
              step_r    <= 1'b1;
              div_num_r <= DIV_N_W'(64'd1 << 33);
              div_den_r <= DIV_D_W'(st_eff);
              div_go_r  <= 1'b1;
              state_r   <= S_OMG;
            end
          end
        end
        S_OMG: begin
          if (div_done) begin
            omega_r <= div_quo[30:0];
            state_r <= S_X;
          end
        end
        S_X: begin
          x_r     <= x_sat;
          state_r <= S_X2;
        end
        S_X2: begin
          x2_r    <= x2_mul[55:16];
          state_r <= S_X3;
        end
        S_X3: begin
          t1_r    <= x2_r * x_r[27:16];
          t2_r    <= t2_mul[55:16];
          q2_r    <= q2_mul[55:16];
          state_r <= S_SUM3;
        end
        S_SUM3: begin
          x3_r    <= 53'(t1_r) + 53'(t2_r);
          state_r <= S_C3;
        end
        S_C3: begin
          c3a_r   <= x3_r[52:16] * C_CUBE;
          c3b_r   <= c3b_mul[31:16];
          state_r <= S_D;
        end
        S_D: begin
          // decay factor E = 2^48 / D, Q0.32
          div_num_r <= DIV_N_W'(64'd1 << 48);
          div_den_r <= d_sum;
          div_go_r  <= 1'b1;
          state_r   <= S_EDIV;
        end
        S_EDIV: begin
          if (div_done) begin
            e_r       <= div_quo[32:0];
            lane_go_r <= 1'b1;
            state_r   <= S_LANE;
          end
        end
        S_LANE: begin
          if (m_done) begin
            snap_r  <= m_snap;
            state_r <= S_FIN;
          end
        end
        default: begin
          // Hold until the output register is free, then commit state and result.
          if (!out_valid_r || !out_stall) begin
            for (int i = 0; i < NUM_AXES; i++) begin
              pos_r[i] <= new_pos[i];
              vel_r[i] <= new_vel[i];
            end
            out_data_r.out_x   <= new_pos[0];
            out_data_r.out_y   <= new_pos[1];
            out_data_r.out_z   <= new_pos[2];
            out_data_r.snapped <= step_r && snap_r;
            out_valid_r        <= 1'b1;
            state_r            <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign cfg_ready = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_go_r |-> !div_busy) else $error("divider restarted while busy");
  a_lanes_lock: assert property (@(posedge clk) disable iff (!rst_n)
    lane_done[0] |-> (lane_done[1] && lane_done[2])) else $error("lanes out of step");
  a_merge_when: assert property (@(posedge clk) disable iff (!rst_n)
    m_done |-> state_r == S_LANE) else $error("snap decision outside lane phase");
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall) else $error("second request taken");
`endif

endmodule
`default_nettype wire

[rtl/core/cdvs_div.sv]
// Restoring divider, one quotient bit per cycle, used for omega and the decay factor.
// Depends on cdvs_pkg for the operand widths.
`timescale 1ns / 1ps
`default_nettype none
module cdvs_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [cdvs_pkg::DIV_N_W-1:0] num,
  input  wire logic [cdvs_pkg::DIV_D_W-1:0] den,
  output logic                              busy,
  output logic                              done,
  output logic [cdvs_pkg::DIV_N_W-1:0]      quo
);
  import cdvs_pkg::*;

  logic [DIV_D_W:0]   rem_r;
  logic [DIV_N_W-1:0] quo_r;
  logic [DIV_D_W-1:0] den_r;
  logic [5:0]         cnt_r;
  logic               busy_r;
  logic               done_r;

  logic [DIV_D_W:0] rem_sh;
  logic [DIV_D_W:0] rem_dif;
  logic             fits;

  assign rem_sh  = {rem_r[DIV_D_W-1:0], quo_r[DIV_N_W-1]};
  assign fits    = rem_sh >= {1'b0, den_r};
  assign rem_dif = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= '0;
        quo_r  <= num;
        den_r  <= den;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? rem_dif : rem_sh;
        quo_r <= {quo_r[DIV_N_W-2:0], fits};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_N_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

[rtl/core/cdvs_lane.sv]
// One axis of the spring step: chained saturating products, each built from a low and a high 24x33 partial product.
// Depends on cdvs_pkg for wide types, saturation helpers and the lane result struct.
`timescale 1ns / 1ps
`default_nettype none
module cdvs_lane (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] cur,
  input  wire logic signed [31:0] vel,
  input  wire logic signed [31:0] tgt,
  input  wire logic [30:0]        omega,
  input  wire logic [15:0]        dt,
  input  wire logic [32:0]        e,
  output logic                    done,
  output cdvs_pkg::lane_res_t     res
);
  import cdvs_pkg::*;

  typedef enum logic [1:0] {L_IDLE, L_LO, L_HI, L_DOT} lstate_t;
  typedef enum logic [2:0] {OP_A, OP_TMP, OP_NV, OP_VEL, OP_POS} op_t;

  lstate_t            state_r;
  op_t                op_r;
  logic               done_r;
  logic signed [31:0] c_r, t_r, v_r, nv_r, pos_r;
  wide_t              chg_r, opnd_r, tmp_r, w_r;
  logic [56:0]        plo_r;
  logic signed [65:0] dot_r;

  logic        neg;
  logic [48:0] mag_full;
  logic [47:0] mag;
  logic [32:0] b;
  logic [56:0] prod_hi;
  logic [80:0] prod;
  logic [80:0] shf;
  logic [46:0] rmag;
  wide_t       rs;
  sum_t        chg_sum;
  sum_t        pos_sum;
  logic signed [32:0] p, q;

  assign neg      = opnd_r[48];
  assign mag_full = neg ? 49'(-opnd_r) : 49'(opnd_r);
  assign mag      = mag_full[47:0];

  always_comb begin
    unique case (op_r)
      OP_A, OP_NV: b = {2'b0, omega};
      OP_TMP:      b = {17'b0, dt};
      default:     b = e;
    endcase
  end

  assign prod_hi = mag[47:24] * b;
  assign prod    = {prod_hi, 24'd0} + 81'(plo_r);

  always_comb begin
    unique case (op_r)
      OP_TMP:      shf = prod >> 14;
      OP_A, OP_NV: shf = prod >> 16;
      default:     shf = prod >> 32;
    endcase
  end

  assign rmag    = (shf > 81'(WIDE_LIM_U)) ? WIDE_LIM_U : shf[46:0];
  assign rs      = neg ? -$signed({2'b0, rmag}) : $signed({2'b0, rmag});
  assign chg_sum = ext32(cur) - ext32(tgt);
  assign pos_sum = ext32(t_r) + extw(rs);
  assign p       = {t_r[31], t_r} - {c_r[31], c_r};
  assign q       = {pos_r[31], pos_r} - {t_r[31], t_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      op_r    <= OP_A;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        L_IDLE: begin
          if (start) begin
            c_r     <= cur;
            t_r     <= tgt;
            v_r     <= vel;
            chg_r   <= chg_sum[48:0];
            opnd_r  <= chg_sum[48:0];
            op_r    <= OP_A;
            state_r <= L_LO;
          end
        end
        L_LO: begin
          plo_r   <= mag[23:0] * b;
          state_r <= L_HI;
        end
        L_HI: begin
          state_r <= L_LO;
          unique case (op_r)
            OP_A: begin
              opnd_r <= sat_w(ext32(v_r) + extw(rs));
              op_r   <= OP_TMP;
            end
            OP_TMP: begin
              tmp_r  <= rs;
              opnd_r <= rs;
              op_r   <= OP_NV;
            end
            OP_NV: begin
              opnd_r <= sat_w(ext32(v_r) - extw(rs));
              w_r    <= sat_w(extw(chg_r) + extw(tmp_r));
              op_r   <= OP_VEL;
            end
            OP_VEL: begin
              nv_r   <= sat32(rs);
              opnd_r <= w_r;
              op_r   <= OP_POS;
            end
            default: begin
              pos_r   <= sat32(pos_sum[48:0]);
              state_r <= L_DOT;
            end
          endcase
        end
        default: begin
          dot_r   <= p * q;
          done_r  <= 1'b1;
          state_r <= L_IDLE;
        end
      endcase
    end
  end

  assign done = done_r;
  assign res  = '{pos: pos_r, vel: nv_r, dot: dot_r};

endmodule
`default_nettype wire

[rtl/core/cdvs_merge.sv]
// Combines the three per-axis overshoot products into the snap decision.
// Depends on cdvs_pkg for the lane result struct.
`timescale 1ns / 1ps
`default_nettype none
module cdvs_merge (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire cdvs_pkg::lane_res_t lane [cdvs_pkg::NUM_AXES],
  output logic                     done,
  output logic                     snap
);
  import cdvs_pkg::*;

  logic               done_r;
  logic               snap_r;
  logic signed [67:0] dsum;

  // Dot product of (target - position) and (new position - target).
  assign dsum = {{2{lane[0].dot[65]}}, lane[0].dot}
              + {{2{lane[1].dot[65]}}, lane[1].dot}
              + {{2{lane[2].dot[65]}}, lane[2].dot};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
      snap_r <= 1'b0;
    end else begin
      done_r <= start;
      if (start) begin
        snap_r <= dsum > 68'sd0;
      end
    end
  end

  assign done = done_r;
  assign snap = snap_r;

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking bench for the critically damped 3-D smoother: random and directed requests,
// a bit-exact spring predictor and a result scoreboard. Depends on cdvs_pkg and the RTL.
`timescale 1ns / 1ps
module testbench;
  import cdvs_pkg::*;

  localparam longint   WIDE_BOUND = 64'sd140737488355327;
  localparam int       WATCHDOG_LIMIT = 20000;
  localparam int       SETTLE_CYCLES = 200;
  localparam int       MAX_REPORTS = 10;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_res_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [23:0] cfg_data = '0;

  critically_damped_vector_smoother u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: spring time register, held position and velocity per axis.
  logic [23:0] model_smooth_time = ST_RESET;
  int          model_pos [3] = '{0, 0, 0};
  int          model_vel [3] = '{0, 0, 0};

  in_req_t  pending_requests [$];
  out_res_t expected_results [$];
  bit       in_took = 1'b0;
  bit       no_idling = 1'b0;
  int       mismatches = 0;
  int       quiet_cycles = 0;
  bit       failed = 1'b0;

  function automatic longint clamp_wide(longint v);
    if (v > WIDE_BOUND) return WIDE_BOUND;
    if (v < -WIDE_BOUND) return -WIDE_BOUND;
    return v;
  endfunction

  function automatic int clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return int'(v);
  endfunction

  // Magnitude times an unsigned factor, shifted down, saturated; sign restored.
  function automatic longint mul_shift(longint a, logic [63:0] b, int sh);
    logic [63:0]  mag;
    logic [127:0] prod;
    mag = (a < 0) ? -a : a;
    prod = ({64'd0, mag} * {64'd0, b}) >> sh;
    if (prod > 128'(WIDE_BOUND)) prod = 128'(WIDE_BOUND);
    return (a < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  // Scale by the Q0.32 decay factor, truncating the magnitude.
  function automatic longint apply_decay(longint a, logic [63:0] e);
    logic [63:0]  mag;
    logic [127:0] prod;
    mag = (a < 0) ? -a : a;
    prod = ({64'd0, mag} * {64'd0, e}) >> 32;
    return (a < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic out_res_t predict_smooth_step(in_req_t req);
    out_res_t    res;
    longint      tgt [3];
    int          npos [3];
    int          nvel [3];
    logic [63:0] st, omega, x, x2, x3, c3, d, e, dt;
    longint      change, a, temp, nv, o;
    logic signed [127:0] dot;
    tgt[0] = req.target_x;
    tgt[1] = req.target_y;
    tgt[2] = req.target_z;
    dt = req.delta_time;
    res = '0;
    if (req.seed) begin
      for (int i = 0; i < 3; i++) begin
        model_pos[i] = int'(tgt[i]);
        model_vel[i] = 0;
      end
    end else if (dt != 0) begin
      st = (model_smooth_time < ST_FLOOR) ? ST_FLOOR : model_smooth_time;
      omega = (64'd1 << 33) / st;
      x = (omega * dt) >> 14;
      if (x > X_MAX) x = X_MAX;
      x2 = (x * x) >> 16;
      x3 = 64'(({64'd0, x2} * {64'd0, x}) >> 16);
      c3 = 64'(({64'd0, x3} * 128'(C_CUBE)) >> 16);
      d = 64'd65536 + x + ((x2 * C_QUAD) >> 16) + c3;
      e = (64'd1 << 48) / d;
      dot = 0;
      for (int i = 0; i < 3; i++) begin
        change = longint'(model_pos[i]) - tgt[i];
        a = clamp_wide(longint'(model_vel[i]) + mul_shift(change, omega, 16));
        temp = mul_shift(a, dt, 14);
        nv = apply_decay(clamp_wide(longint'(model_vel[i]) - mul_shift(temp, omega, 16)), e);
        o = tgt[i] + apply_decay(clamp_wide(change + temp), e);
        npos[i] = clamp32(o);
        nvel[i] = clamp32(nv);
        // overshoot test: did the step carry the position past the target?
        dot += 128'(tgt[i] - longint'(model_pos[i])) * 128'(longint'(npos[i]) - tgt[i]);
      end
      if (dot > 0) begin
        res.snapped = 1'b1;
        for (int i = 0; i < 3; i++) begin
          npos[i] = int'(tgt[i]);
          nvel[i] = 0;
        end
      end
      model_pos = npos;
      model_vel = nvel;
    end
    res.out_x = model_pos[0];
    res.out_y = model_pos[1];
    res.out_z = model_pos[2];
    return res;
  endfunction

  // Rising edge: take requests into the predictor, check results, keep the watchdog.
  always @(posedge clk) begin
    out_res_t want;
    in_took = in_valid && !in_stall;
    if (in_took) expected_results.push_back(predict_smooth_step(in_data));
    if (out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("unexpected result %h", out_data);
      end else begin
        want = expected_results.pop_front();
        if (want !== out_data) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected x=%h y=%h z=%h snap=%b got x=%h y=%h z=%h snap=%b",
                     want.out_x, want.out_y, want.out_z, want.snapped,
                     out_data.out_x, out_data.out_y, out_data.out_z, out_data.snapped);
        end
      end
    end
    if (in_took || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Falling edge: advance the request channel and randomise back-pressure.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_took) begin
        if (pending_requests.size() > 0 && (no_idling || $urandom_range(0, 99) >= 31)) begin
          in_valid <= 1'b1;
          in_data <= pending_requests.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= !no_idling && ($urandom_range(0, 99) < 31);
    end
  end

  // Running centre point so most targets cluster around it.
  int centre [3] = '{0, 0, 0};

  function automatic in_req_t make_request(bit seed, int tx, int ty, int tz, int dt);
    in_req_t r;
    r.seed = seed;
    r.target_x = tx;
    r.target_y = ty;
    r.target_z = tz;
    r.delta_time = dt[15:0];
    return r;
  endfunction

  function automatic in_req_t random_request();
    in_req_t r;
    int      pick;
    int      tgt [3];
    int      span;
    pick = $urandom_range(0, 99);
    span = 1 << $urandom_range(4, 24);
    if ($urandom_range(0, 19) == 0)
      for (int i = 0; i < 3; i++) centre[i] = $urandom;
    for (int i = 0; i < 3; i++)
      tgt[i] = (pick < 12) ? int'($urandom) : centre[i] + $urandom_range(0, span) - span / 2;
    r = make_request($urandom_range(0, 99) < 6, tgt[0], tgt[1], tgt[2], 0);
    case ($urandom_range(0, 9))
      0:       r.delta_time = 16'd0;
      1, 2:    r.delta_time = 16'($urandom_range(0, 65535));
      default: r.delta_time = 16'($urandom_range(1, 1200));
    endcase
    return r;
  endfunction

  // Hold until every queued request has gone in and every result is back.
  task automatic drain();
    do @(posedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_smooth_time(logic [23:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    model_smooth_time = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  localparam int PHASES = 9;
  logic [23:0] phase_setting [PHASES];

  initial begin
    phase_setting[0] = ST_RESET;
    phase_setting[1] = 24'd0;
    phase_setting[2] = ST_FLOOR;
    phase_setting[3] = 24'hFF_FFFF;
    phase_setting[4] = 24'd6554;
    for (int p = 5; p < PHASES; p++)
      phase_setting[p] = (p % 2) ? 24'($urandom_range(7, 70000))
                                 : 24'($urandom_range(0, 24'hFF_FFFF));
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero step from reset, seeds at extremes, huge and tiny steps, overshoot.
    pending_requests.push_back(make_request(0, 100, -100, 5, 0));
    pending_requests.push_back(make_request(0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 16'hFFFF));
    pending_requests.push_back(make_request(0, 32'sh8000_0000, 32'sh7FFF_FFFF, -1, 1));
    pending_requests.push_back(make_request(1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0));
    pending_requests.push_back(make_request(0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1));
    pending_requests.push_back(make_request(0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 300));
    pending_requests.push_back(make_request(0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'hFFFF));
    pending_requests.push_back(make_request(1, 0, 0, 0, 16'hFFFF));
    pending_requests.push_back(make_request(0, 65536, 0, 0, 1638));
    pending_requests.push_back(make_request(0, 65536, 0, 0, 1638));
    pending_requests.push_back(make_request(0, -65536, 0, 0, 1638));
    pending_requests.push_back(make_request(0, -65536, 0, 0, 0));
    pending_requests.push_back(make_request(0, 0, 65536, -65536, 16384));
    pending_requests.push_back(make_request(0, 0, 0, 0, 16'h8000));
    pending_requests.push_back(make_request(0, 1, 1, 1, 1));
    pending_requests.push_back(make_request(1, -1, -1, -1, 1));
    pending_requests.push_back(make_request(0, 1 << 20, -(1 << 20), 1 << 18, 160));

    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) write_smooth_time(phase_setting[p]);
      no_idling = (p == 4);
      for (int n = 0; n < 150; n++) pending_requests.push_back(random_request());
      drain();
    end

    if (!failed && mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/cdvs_pkg.sv
rtl/core/cdvs_div.sv
rtl/core/cdvs_lane.sv
rtl/core/cdvs_merge.sv
rtl/core/critically_damped_vector_smoother.sv
tb/sv/testbench.sv
